/* design/pixel_quantize_pack_5bit_defines.svh */
// assertion macros shared by the pixel quantizer and packer
`ifndef PIXEL_QUANTIZE_PACK_5BIT_DEFINES_SVH
`define PIXEL_QUANTIZE_PACK_5BIT_DEFINES_SVH

// clocked check, off while reset is held
`define PQP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// clocked check that also covers the reset cycles
`define PQP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* design/pqp_pkg.sv */
// types, constants and arithmetic helpers of the pixel quantizer and packer
package pqp_pkg;

    localparam int VALUE_BITS_DEF       = 5;
    localparam int VALUES_PER_BLOCK_DEF = 8;
    localparam int WORD_BITS            = 40;
    localparam int COUNT_BITS           = 4;
    localparam int PIX_BITS             = 8;
    localparam int Q_DEPTH              = 4;
    localparam int OQ_DEPTH             = 4;
    localparam int PADDR_W              = 3;

    // register index of the mode register
    localparam logic CFG_GRAY_IDX = 1'b0;

    // one classified pixel: three channel values, or one averaged value
    typedef struct packed {
        logic [2:0][PIX_BITS-1:0] vals;
        logic                     multi;
        logic                     last;
    } t_pqp_entry;

    // one packed block as it leaves the block
    typedef struct packed {
        logic [WORD_BITS-1:0]  block_word;
        logic [COUNT_BITS-1:0] value_count;
        logic                  last_block;
    } t_pqp_blk;

    // floor(s/3) for s up to 765, via multiply by 683/2048
    function automatic logic [PIX_BITS-1:0] div3(input logic [9:0] s);
        logic [19:0] p;
        p = 20'(s) * 20'd683;
        return p[18:11];
    endfunction

    // floor(v*top/255), with x/255 done as (x + (x>>8) + 1) >> 8
    function automatic logic [PIX_BITS-1:0] quant(input logic [PIX_BITS-1:0] v,
                                                  input logic [PIX_BITS-1:0] top);
        logic [15:0] x;
        logic [16:0] y;
        x = 16'(v) * 16'(top);
        y = 17'(x) + 17'(x[15:8]) + 17'd1;
        return y[15:8];
    endfunction

endpackage

/* design/pqp_ifs.sv */
// valid/ready channels for pixel words and packed block words
interface pqp_pix_if;
    logic                          valid;
    logic                          ready;
    logic [pqp_pkg::PIX_BITS-1:0]  red;
    logic [pqp_pkg::PIX_BITS-1:0]  green;
    logic [pqp_pkg::PIX_BITS-1:0]  blue;
    logic                          last_pixel;

    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface pqp_blk_if;
    logic                            valid;
    logic                            ready;
    logic [pqp_pkg::WORD_BITS-1:0]   block_word;
    logic [pqp_pkg::COUNT_BITS-1:0]  value_count;
    logic                            last_block;

    modport source (output valid, block_word, value_count, last_block, input ready);
    modport sink   (input valid, block_word, value_count, last_block, output ready);
endinterface

/* design/pqp_fifo.sv */
// small queue of classified pixels between front and back
module pqp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_valid,
    output logic                o_wr_ready,
    input  pqp_pkg::t_pqp_entry i_wr_data,
    output logic                o_rd_valid,
    input  logic                i_rd_ready,
    output pqp_pkg::t_pqp_entry o_rd_data
);
    localparam int PTR_W = $clog2(pqp_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(pqp_pkg::Q_DEPTH + 1);

    pqp_pkg::t_pqp_entry r_mem [pqp_pkg::Q_DEPTH];
    logic [PTR_W-1:0]    r_wp;
    logic [PTR_W-1:0]    r_rp;
    logic [CNT_W-1:0]    r_cnt;
    logic                push;
    logic                pop;

    assign o_wr_ready = (r_cnt != CNT_W'(pqp_pkg::Q_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

/* design/pqp_front.sv */
// front end: takes pixel words, averages and quantizes them
module pqp_front #(
    parameter int VALUE_BITS = pqp_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pqp_pix_if.sink             i_pix,
    input  logic                i_gray,
    output pqp_pkg::t_pqp_entry o_ent,
    output logic                o_ent_valid,
    input  logic                i_ent_ready
);
    localparam logic [pqp_pkg::PIX_BITS-1:0] QTOP =
        pqp_pkg::PIX_BITS'((1 << VALUE_BITS) - 1);

    logic                         r_s1_valid;
    logic [pqp_pkg::PIX_BITS-1:0] r_red;
    logic [pqp_pkg::PIX_BITS-1:0] r_green;
    logic [pqp_pkg::PIX_BITS-1:0] r_blue;
    logic [pqp_pkg::PIX_BITS-1:0] r_avg;
    logic                         r_last;

    assign i_pix.ready = !r_s1_valid || i_ent_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    // average for gray mode, registered before the quantizer multiply
    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_red   <= i_pix.red;
            r_green <= i_pix.green;
            r_blue  <= i_pix.blue;
            r_last  <= i_pix.last_pixel;
            r_avg   <= pqp_pkg::div3(10'(i_pix.red) + 10'(i_pix.green) + 10'(i_pix.blue));
        end
    end

    always_comb begin
        o_ent_valid   = r_s1_valid;
        o_ent.multi   = !i_gray;
        o_ent.last    = r_last;
        o_ent.vals[0] = pqp_pkg::quant(i_gray ? r_avg : r_red, QTOP);
        o_ent.vals[1] = pqp_pkg::quant(r_green, QTOP);
        o_ent.vals[2] = pqp_pkg::quant(r_blue, QTOP);
    end

endmodule

/* design/pqp_back.sv */
// back end: packs quantized values into blocks and queues block words
module pqp_back #(
    parameter int VALUE_BITS       = pqp_pkg::VALUE_BITS_DEF,
    parameter int VALUES_PER_BLOCK = pqp_pkg::VALUES_PER_BLOCK_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pqp_pkg::t_pqp_entry i_ent,
    input  logic                i_ent_valid,
    output logic                o_ent_ready,
    pqp_blk_if.source           o_blk
);
    localparam int ACC_BITS = VALUE_BITS * VALUES_PER_BLOCK;
    localparam int HELD_W   = $clog2(VALUES_PER_BLOCK + 1);
    localparam int OPTR_W   = $clog2(pqp_pkg::OQ_DEPTH);
    localparam int OCNT_W   = $clog2(pqp_pkg::OQ_DEPTH + 1);
    localparam int WIDE     = 64;

    logic [ACC_BITS-1:0]  r_acc;
    logic [HELD_W-1:0]    r_held;
    logic [ACC_BITS-1:0]  n_acc;
    logic [HELD_W-1:0]    n_held;
    pqp_pkg::t_pqp_blk    res [2];
    logic [1:0]           nres;

    pqp_pkg::t_pqp_blk    r_oq [pqp_pkg::OQ_DEPTH];
    logic [OPTR_W-1:0]    r_wp;
    logic [OPTR_W-1:0]    r_rp;
    logic [OCNT_W-1:0]    r_ocnt;
    logic                 pop;
    logic                 deq;

    // left-align the held values to the top of the block word
    function automatic pqp_pkg::t_pqp_blk mk_blk(input logic [ACC_BITS-1:0] a,
                                                 input logic [HELD_W-1:0]   cnt,
                                                 input logic                lst);
        logic [WIDE-1:0]   w;
        pqp_pkg::t_pqp_blk b;
        w             = WIDE'(a) << (WIDE - ACC_BITS);
        b.block_word  = w[WIDE-1 -: pqp_pkg::WORD_BITS];
        b.value_count = pqp_pkg::COUNT_BITS'(cnt);
        b.last_block  = lst;
        return b;
    endfunction

    // packing of one entry: up to three values, up to two blocks
    always_comb begin
        n_acc  = r_acc;
        n_held = r_held;
        nres   = 2'd0;
        res[0] = '0;
        res[1] = '0;
        for (int k = 0; k < 3; k++) begin
            if (k == 0 || i_ent.multi) begin
                for (int s = 0; s < VALUES_PER_BLOCK; s++) begin
                    if (n_held == HELD_W'(s)) begin
                        n_acc[ACC_BITS-1-s*VALUE_BITS -: VALUE_BITS] =
                            i_ent.vals[k][VALUE_BITS-1:0];
                    end
                end
                n_held = n_held + HELD_W'(1);
                if (n_held == HELD_W'(VALUES_PER_BLOCK)) begin
                    // full block; a third block in one word is dropped
                    if (nres == 2'd0) begin
                        res[0] = mk_blk(n_acc, n_held, 1'b0);
                        nres   = 2'd1;
                    end else if (nres == 2'd1) begin
                        res[1] = mk_blk(n_acc, n_held, 1'b0);
                        nres   = 2'd2;
                    end
                    n_acc  = '0;
                    n_held = '0;
                end
            end
        end
        if (i_ent.last) begin
            if (n_held != '0) begin
                // partial block flush
                if (nres == 2'd0) begin
                    res[0] = mk_blk(n_acc, n_held, 1'b1);
                    nres   = 2'd1;
                end else if (nres == 2'd1) begin
                    res[1] = mk_blk(n_acc, n_held, 1'b1);
                    nres   = 2'd2;
                end
            end else if (nres == 2'd2) begin
                res[1].last_block = 1'b1;
            end else if (nres == 2'd1) begin
                res[0].last_block = 1'b1;
            end
            n_acc  = '0;
            n_held = '0;
        end
    end

    // take an entry only when two output slots are surely free
    assign o_ent_ready = (r_ocnt <= OCNT_W'(pqp_pkg::OQ_DEPTH - 2));
    assign pop         = i_ent_valid && o_ent_ready;
    assign deq         = o_blk.valid && o_blk.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
        end else if (pop) begin
            r_acc  <= n_acc;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_ocnt <= '0;
        end else begin
            if (pop) begin
                r_wp <= r_wp + OPTR_W'(nres);
            end
            if (deq) begin
                r_rp <= r_rp + OPTR_W'(1);
            end
            r_ocnt <= r_ocnt + (pop ? OCNT_W'(nres) : OCNT_W'(0)) - OCNT_W'(deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && nres != 2'd0) begin
            r_oq[r_wp] <= res[0];
        end
        if (pop && nres == 2'd2) begin
            r_oq[r_wp + OPTR_W'(1)] <= res[1];
        end
    end

    assign o_blk.valid       = (r_ocnt != '0);
    assign o_blk.block_word  = r_oq[r_rp].block_word;
    assign o_blk.value_count = r_oq[r_rp].value_count;
    assign o_blk.last_block  = r_oq[r_rp].last_block;

endmodule

/* design/pixel_quantize_pack_5bit.sv */
// top level of the pixel quantizer and 5-bit block packer
`include "pixel_quantize_pack_5bit_defines.svh"

// Takes one RGB pixel word per clock and packs quantized values, floor(v*31/255)
// at the default width, MSB first into 40-bit block words, first value at bit 39.
// In colour mode (grayscale_mode = 0) each pixel gives red, green and blue values;
// in gray mode it gives one value of (r+g+b)/3. A block word leaves when eight
// values are held; a pixel marked last_pixel flushes any partial block
// zero-padded with its value count and marks the final block with last_block.
// One pixel word is accepted per clock while the pixel queue has room. A block
// word passes through one front stage (average), a 4-word pixel queue, then the
// packer, which writes a 4-word block queue that drives the output.
// The packer writes up to two block words per pixel and takes a pixel while at most
// two block words wait, so it pauses only when the receiver stalls or two-block
// pixels come faster than the output drains.
// grayscale_mode sits at APB address 0 (bit 0); write it only while idle.
module pixel_quantize_pack_5bit #(
    parameter int VALUE_BITS       = pqp_pkg::VALUE_BITS_DEF,
    parameter int VALUES_PER_BLOCK = pqp_pkg::VALUES_PER_BLOCK_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pqp_pix_if.sink                     i_pix,
    pqp_blk_if.source                   o_blk,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pqp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    logic                r_gray;
    pqp_pkg::t_pqp_entry fe_ent;
    logic                fe_valid;
    logic                fe_ready;
    pqp_pkg::t_pqp_entry be_ent;
    logic                be_valid;
    logic                be_ready;

    logic [pqp_pkg::COUNT_BITS-1:0] full_cnt;
    logic                           blk_cnt_bad;
    logic                           blk_short_open;

    // config register, word index taken from paddr[2]
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pqp_pkg::CFG_GRAY_IDX) ? {31'd0, r_gray} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == pqp_pkg::CFG_GRAY_IDX) begin
            r_gray <= pwdata[0];
        end
    end

    // front: accept, average, quantize
    pqp_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_gray      (r_gray),
        .o_ent       (fe_ent),
        .o_ent_valid (fe_valid),
        .i_ent_ready (fe_ready)
    );

    // queue decouples the pixel side from the packer
    pqp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_valid),
        .o_wr_ready (fe_ready),
        .i_wr_data  (fe_ent),
        .o_rd_valid (be_valid),
        .i_rd_ready (be_ready),
        .o_rd_data  (be_ent)
    );

    // back: pack values, queue block words
    pqp_back #(
        .VALUE_BITS       (VALUE_BITS),
        .VALUES_PER_BLOCK (VALUES_PER_BLOCK)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent       (be_ent),
        .i_ent_valid (be_valid),
        .o_ent_ready (be_ready),
        .o_blk       (o_blk)
    );

    // terms of the output checks
    assign full_cnt       = pqp_pkg::COUNT_BITS'(VALUES_PER_BLOCK);
    assign blk_cnt_bad    = o_blk.valid
                            && (o_blk.value_count == '0 || o_blk.value_count > full_cnt);
    assign blk_short_open = o_blk.valid && !o_blk.last_block
                            && o_blk.value_count != full_cnt;

    // every block word carries between one and a full block of values
    `PQP_ASSERT(a_count_range, !blk_cnt_bad, "block word with bad value count")
    // only the final block of an image may be short
    `PQP_ASSERT(a_short_is_last, !blk_short_open, "short block word not marked last")
    // nothing leaves right after reset
    `PQP_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_blk.valid, "block word valid after reset")

endmodule
